// File: hdl/khwt_pkg.sv
// Shared types and constants for the keyed heartbeat watchdog table.
package khwt_pkg;

    localparam int KEY_W          = 64;
    localparam int TICK_W         = 14;
    localparam int OP_W           = 2;
    localparam int KIND_W         = 3;
    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 14'd10000;

    // Input operation codes (code 3 is ignored)
    typedef enum logic [OP_W-1:0] {
        OP_REGISTER  = 2'd0,
        OP_HEARTBEAT = 2'd1,
        OP_TICK      = 2'd2
    } op_t;

    // Result event codes
    typedef enum logic [KIND_W-1:0] {
        EV_REGISTERED = 3'd0,
        EV_DUPLICATE  = 3'd1,
        EV_REARMED    = 3'd2,
        EV_UNKNOWN    = 3'd3,
        EV_EXPIRED    = 3'd4,
        EV_FULL       = 3'd5
    } event_kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH,
        ST_FLUSH
    } state_t;

endpackage

// File: hdl/keyed_heartbeat_watchdog_table.sv
// Keyed heartbeat watchdog table: top level with table walk sequencer.
//
// Keeps up to TABLE_DEPTH 128-bit client keys, each with a one-shot countdown.
// Every accepted beat walks the whole table, one entry per cycle while the result
// channel does not hold off an expired entry, through a single registered read
// port on the key and countdown memories, with one shared 128-bit key compare and
// one countdown decrement. A register or heartbeat beat walks the table and then
// decides and writes back as its result goes out; a tick beat walks the table and
// then flushes its final held result. Either waits while the result channel holds
// off a beat. s_tready is high only between items and comes back with the final
// result, so a new beat is not accepted until the last one is through. Expired entries
// are held one deep so the final one can carry tlast; a tick that expires nothing
// gives no result beat, and operation code 3 is dropped. timeout_ticks of zero
// arms for a single tick.
module keyed_heartbeat_watchdog_table #(
    parameter int TABLE_DEPTH = khwt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [2*khwt_pkg::KEY_W-1:0]   s_tdata,   // [63:0] key_high, [127:64] key_low
    input  logic [khwt_pkg::OP_W-1:0]      s_tuser,   // [1:0] operation
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [2*khwt_pkg::KEY_W-1:0]   m_tdata,   // [63:0] out_key_high, [127:64] out_key_low
    output logic [khwt_pkg::KIND_W-1:0]    m_tuser,   // [2:0] event_kind
    output logic                           m_tlast,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [khwt_pkg::TICK_W-1:0]    cfg_wr_data // timeout_ticks
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KW    = khwt_pkg::KEY_W;
    localparam int TW    = khwt_pkg::TICK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // sequencer and item registers
    khwt_pkg::state_t       state_reg, state_next;
    khwt_pkg::op_t          op_reg, op_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [KW-1:0]          key_hi_reg, key_hi_next;
    logic [KW-1:0]          key_lo_reg, key_lo_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic                   free_reg, free_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   pend_reg, pend_next;
    logic [KW-1:0]          pend_hi_reg, pend_hi_next;
    logic [KW-1:0]          pend_lo_reg, pend_lo_next;
    logic [TW-1:0]          timeout_reg;

    // per-entry flags
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] armed_reg, armed_next;

    // output register
    logic                      m_valid_reg;
    khwt_pkg::event_kind_t     out_kind_reg;
    logic [KW-1:0]             out_hi_reg, out_lo_reg;
    logic                      out_last_reg;

    logic                      out_load;
    khwt_pkg::event_kind_t     out_kind;
    logic [KW-1:0]             out_hi, out_lo;
    logic                      out_last;
    logic                      out_free;

    // table memories
    logic [KW-1:0]          key_hi_mem [TABLE_DEPTH];
    logic [KW-1:0]          key_lo_mem [TABLE_DEPTH];
    logic [TW-1:0]          cnt_mem    [TABLE_DEPTH];
    logic [KW-1:0]          rd_key_hi_reg, rd_key_lo_reg;
    logic [TW-1:0]          rd_cnt_reg;
    logic [IDX_W-1:0]       rd_addr;

    logic                   key_we;
    logic [IDX_W-1:0]       key_wa;
    logic                   cnt_we;
    logic [IDX_W-1:0]       cnt_wa;
    logic [TW-1:0]          cnt_wd;

    logic [TW-1:0]          load_val;
    logic                   entry_hit;
    logic                   advance;

    // ports
    assign s_tready = (state_reg == khwt_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_lo_reg, out_hi_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign load_val = (timeout_reg == '0) ? TW'(1) : timeout_reg;
    assign rd_addr  = idx_next;

    // shared key compare against the entry read last cycle
    assign entry_hit = valid_reg[idx_reg] &&
                       (rd_key_hi_reg == key_hi_reg) && (rd_key_lo_reg == key_lo_reg);

    // next state and datapath control
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        key_hi_next   = key_hi_reg;
        key_lo_next   = key_lo_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        pend_next     = pend_reg;
        pend_hi_next  = pend_hi_reg;
        pend_lo_next  = pend_lo_reg;
        valid_next    = valid_reg;
        armed_next    = armed_reg;
        out_load      = 1'b0;
        out_kind      = khwt_pkg::EV_EXPIRED;
        out_hi        = pend_hi_reg;
        out_lo        = pend_lo_reg;
        out_last      = 1'b0;
        key_we        = 1'b0;
        key_wa        = free_idx_reg;
        cnt_we        = 1'b0;
        cnt_wa        = idx_reg;
        cnt_wd        = load_val;
        advance       = 1'b1;

        case (state_reg)
            khwt_pkg::ST_IDLE: begin
                idx_next = '0;
                if (s_tvalid) begin
                    op_next     = khwt_pkg::op_t'(s_tuser);
                    key_hi_next = s_tdata[KW-1:0];
                    key_lo_next = s_tdata[2*KW-1:KW];
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    pend_next   = 1'b0;
                    if (s_tuser inside {khwt_pkg::OP_REGISTER, khwt_pkg::OP_HEARTBEAT,
                                        khwt_pkg::OP_TICK}) begin
                        state_next = khwt_pkg::ST_WALK;
                    end
                end
            end

            khwt_pkg::ST_WALK: begin
                if (op_reg == khwt_pkg::OP_TICK) begin
                    if (armed_reg[idx_reg]) begin
                        if (rd_cnt_reg > TW'(1)) begin
                            // count down
                            cnt_we = 1'b1;
                            cnt_wd = rd_cnt_reg - TW'(1);
                        end else if (pend_reg && !out_free) begin
                            advance = 1'b0;
                        end else begin
                            // expire: push any held event, hold this one
                            if (pend_reg) begin
                                out_load = 1'b1;
                            end
                            armed_next[idx_reg] = 1'b0;
                            pend_next    = 1'b1;
                            pend_hi_next = rd_key_hi_reg;
                            pend_lo_next = rd_key_lo_reg;
                        end
                    end
                end else begin
                    // search for key match and first free slot
                    if (entry_hit && !hit_reg) begin
                        hit_next     = 1'b1;
                        hit_idx_next = idx_reg;
                    end
                    if (!valid_reg[idx_reg] && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                end
                if (advance) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = (op_reg == khwt_pkg::OP_TICK) ? khwt_pkg::ST_FLUSH
                                                                   : khwt_pkg::ST_FINISH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            khwt_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    out_hi     = key_hi_reg;
                    out_lo     = key_lo_reg;
                    state_next = khwt_pkg::ST_IDLE;
                    if (op_reg == khwt_pkg::OP_REGISTER) begin
                        if (hit_reg) begin
                            out_kind = khwt_pkg::EV_DUPLICATE;
                        end else if (free_reg) begin
                            out_kind = khwt_pkg::EV_REGISTERED;
                            key_we   = 1'b1;
                            cnt_we   = 1'b1;
                            cnt_wa   = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            armed_next[free_idx_reg] = 1'b1;
                        end else begin
                            out_kind = khwt_pkg::EV_FULL;
                        end
                    end else begin
                        if (hit_reg) begin
                            out_kind = khwt_pkg::EV_REARMED;
                            cnt_we   = 1'b1;
                            cnt_wa   = hit_idx_reg;
                            armed_next[hit_idx_reg] = 1'b1;
                        end else begin
                            out_kind = khwt_pkg::EV_UNKNOWN;
                        end
                    end
                end
            end

            khwt_pkg::ST_FLUSH: begin
                if (!pend_reg) begin
                    state_next = khwt_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    pend_next  = 1'b0;
                    state_next = khwt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = khwt_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= khwt_pkg::ST_IDLE;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            valid_reg   <= '0;
            armed_reg   <= '0;
            m_valid_reg <= 1'b0;
            timeout_reg <= khwt_pkg::TIMEOUT_RESET;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
            armed_reg <= armed_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_hi_reg   <= key_hi_next;
        key_lo_reg   <= key_lo_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        pend_hi_reg  <= pend_hi_next;
        pend_lo_reg  <= pend_lo_next;
        if (out_load) begin
            out_kind_reg <= out_kind;
            out_hi_reg   <= out_hi;
            out_lo_reg   <= out_lo;
            out_last_reg <= out_last;
        end
    end

    // key and countdown memories, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_hi_mem[key_wa] <= key_hi_reg;
            key_lo_mem[key_wa] <= key_lo_reg;
        end
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        rd_key_hi_reg <= key_hi_mem[rd_addr];
        rd_key_lo_reg <= key_lo_mem[rd_addr];
        rd_cnt_reg    <= cnt_mem[rd_addr];
    end

endmodule
